### rtl/mlr_pkg.sv
// Shared definitions for the midpoint line rasterizer.
// Request command codes and the result control bundle; no dependencies.
package mlr_pkg;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  typedef struct packed {
    logic emit;   // this request produces a pixel
    logic last;   // the pixel is the line's second endpoint
  } mlr_res_t;

endpackage

### rtl/mlr_in_reg.sv
// Input register stage: captures one request per cycle from the slave side while empty or while advance is high.
// Depends on nothing; the command sits in tuser, endpoints and colour in tdata.
module mlr_in_reg #(
  parameter int DATA_W = 80
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic              in_tuser,
  input  logic [DATA_W-1:0] in_tdata,
  input  logic              advance,
  output logic              valid_r,
  output logic              cmd_r,
  output logic [DATA_W-1:0] data_r
);

  logic valid_nxt;
  logic take;

  assign in_tready = !valid_r || advance;
  assign take      = in_tvalid && in_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cmd_r  <= in_tuser;
      data_r <= in_tdata;
    end
  end

endmodule

### rtl/mlr_core.sv
// Line state and the per-request setup / step arithmetic.
// Uses mlr_pkg for command codes and the result control struct.
module mlr_core #(
  parameter int COORD_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  fire,
  input  logic                  cmd,
  input  logic [COORD_BITS-1:0] start_x,
  input  logic [COORD_BITS-1:0] start_y,
  input  logic [COORD_BITS-1:0] end_x,
  input  logic [COORD_BITS-1:0] end_y,
  input  logic [31:0]           colour_in,
  output logic [COORD_BITS-1:0] pix_x,
  output logic [COORD_BITS-1:0] pix_y,
  output logic [31:0]           pix_colour,
  output mlr_pkg::mlr_res_t     res
);

  localparam int DLW = COORD_BITS + 1;  // absolute extent
  localparam int DW  = COORD_BITS + 3;  // doubled decision value

  logic [COORD_BITS-1:0] cur_x_r, cur_y_r, tgt_x_r, tgt_y_r;
  logic [COORD_BITS-1:0] cur_x_nxt, cur_y_nxt, tgt_x_nxt, tgt_y_nxt;
  logic [DW-1:0]         dec_r, dec_nxt;
  logic [DLW-1:0]        maj_r, min_r, maj_nxt, min_nxt;
  logic                  xneg_r, yneg_r, ymaj_r;
  logic                  xneg_nxt, yneg_nxt, ymaj_nxt;
  logic                  active_r, active_nxt;
  logic [31:0]           colour_r, colour_nxt;

  // setup
  logic [DLW-1:0] dx, dy, ax, ay, s_maj, s_min;
  logic           s_ymaj;
  // step
  logic [COORD_BITS-1:0] mv_x, mv_y;
  logic                  dec_pos;
  logic [DW-1:0]         min2, maj2;

  assign dx     = {1'b0, end_x} - {1'b0, start_x};
  assign dy     = {1'b0, end_y} - {1'b0, start_y};
  assign ax     = dx[DLW-1] ? (~dx + 1'b1) : dx;
  assign ay     = dy[DLW-1] ? (~dy + 1'b1) : dy;
  assign s_ymaj = ay > ax;
  assign s_maj  = s_ymaj ? ay : ax;
  assign s_min  = s_ymaj ? ax : ay;

  assign mv_x    = xneg_r ? cur_x_r - 1'b1 : cur_x_r + 1'b1;
  assign mv_y    = yneg_r ? cur_y_r - 1'b1 : cur_y_r + 1'b1;
  assign dec_pos = !dec_r[DW-1] && (dec_r != '0);
  assign min2    = {1'b0, min_r, 1'b0};
  assign maj2    = {1'b0, maj_r, 1'b0};

  always_comb begin
    cur_x_nxt  = cur_x_r;
    cur_y_nxt  = cur_y_r;
    tgt_x_nxt  = tgt_x_r;
    tgt_y_nxt  = tgt_y_r;
    dec_nxt    = dec_r;
    maj_nxt    = maj_r;
    min_nxt    = min_r;
    xneg_nxt   = xneg_r;
    yneg_nxt   = yneg_r;
    ymaj_nxt   = ymaj_r;
    active_nxt = active_r;
    colour_nxt = colour_r;
    res.emit   = 1'b0;
    if (fire) begin
      if (cmd == mlr_pkg::CMD_START) begin
        cur_x_nxt  = start_x;
        cur_y_nxt  = start_y;
        tgt_x_nxt  = end_x;
        tgt_y_nxt  = end_y;
        colour_nxt = colour_in;
        xneg_nxt   = dx[DLW-1];
        yneg_nxt   = dy[DLW-1];
        ymaj_nxt   = s_ymaj;
        maj_nxt    = s_maj;
        min_nxt    = s_min;
        dec_nxt    = {1'b0, s_min, 1'b0} - {2'b00, s_maj};
        active_nxt = s_maj != '0;
        res.emit   = 1'b1;
      end else if (active_r) begin
        if (ymaj_r) begin
          cur_y_nxt  = mv_y;
          cur_x_nxt  = dec_pos ? mv_x : cur_x_r;
          active_nxt = mv_y != tgt_y_r;
        end else begin
          cur_x_nxt  = mv_x;
          cur_y_nxt  = dec_pos ? mv_y : cur_y_r;
          active_nxt = mv_x != tgt_x_r;
        end
        dec_nxt  = dec_pos ? dec_r + min2 - maj2 : dec_r + min2;
        res.emit = 1'b1;
      end
    end
    res.last = !active_nxt;
  end

  assign pix_x      = cur_x_nxt;
  assign pix_y      = cur_y_nxt;
  assign pix_colour = colour_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_x_r  <= cur_x_nxt;
    cur_y_r  <= cur_y_nxt;
    tgt_x_r  <= tgt_x_nxt;
    tgt_y_r  <= tgt_y_nxt;
    dec_r    <= dec_nxt;
    maj_r    <= maj_nxt;
    min_r    <= min_nxt;
    xneg_r   <= xneg_nxt;
    yneg_r   <= yneg_nxt;
    ymaj_r   <= ymaj_nxt;
    colour_r <= colour_nxt;
  end

endmodule

### rtl/mlr_out_reg.sv
// Result register on the master side; holds a pixel until it is taken.
// Uses mlr_pkg for the result control struct.
module mlr_out_reg #(
  parameter int DATA_W = 56
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  mlr_pkg::mlr_res_t res,
  input  logic [DATA_W-1:0] data,
  output logic              advance,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [DATA_W-1:0] out_tdata,
  output logic              out_tlast
);

  logic valid_r, valid_nxt;
  logic load;

  assign advance    = !valid_r || out_tready;
  assign load       = fire && res.emit;
  assign out_tvalid = valid_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_tdata <= data;
      out_tlast <= res.last;
    end
  end

endmodule

### rtl/midpoint_line_rasterizer.sv
// Midpoint line rasterizer top level: input register, line core, result register.
// Depends on mlr_pkg, mlr_in_reg, mlr_core and mlr_out_reg.
//
//  channel | dir | tuser   | tdata (low bit up)                          | tlast
//  in_     | in  | command | start_x, start_y, end_x, end_y, colour_in  | -
//  out_    | out | -       | pixel_x, pixel_y, pixel_colour              | last
//
// One request per cycle unless out_ stalls; a request passes the input register, then the result register, to out_.
// Start and step work is one pass of add/compare logic between the two registers.
// rst_n (synchronous) clears the line-active flag and both valid flags.
// A stalled result holds the core; the input register still takes one more request if it is empty.
module midpoint_line_rasterizer #(
  parameter int COORD_BITS = 12
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  logic in_tuser,  // command
  input  logic [((4*COORD_BITS+32+7)/8)*8-1:0] in_tdata,
    // start_x, start_y, end_x, end_y, colour_in, zero fill
  output logic out_tvalid,
  input  logic out_tready,
  output logic [((2*COORD_BITS+32+7)/8)*8-1:0] out_tdata,
    // pixel_x, pixel_y, pixel_colour, zero fill
  output logic out_tlast
);

  localparam int C       = COORD_BITS;
  localparam int IN_W    = ((4*COORD_BITS+32+7)/8)*8;
  localparam int OUT_W   = ((2*COORD_BITS+32+7)/8)*8;

  logic              advance, fire;
  logic              req_valid, req_cmd;
  logic [IN_W-1:0]   req_data;
  logic [C-1:0]      pix_x, pix_y;
  logic [31:0]       pix_colour;
  logic [OUT_W-1:0]  pix_data;
  mlr_pkg::mlr_res_t res;

  mlr_in_reg #(.DATA_W(IN_W)) u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .advance   (advance),
    .valid_r   (req_valid),
    .cmd_r     (req_cmd),
    .data_r    (req_data)
  );

  assign fire = req_valid && advance;

  mlr_core #(.COORD_BITS(C)) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .cmd        (req_cmd),
    .start_x    (req_data[C-1:0]),
    .start_y    (req_data[2*C-1:C]),
    .end_x      (req_data[3*C-1:2*C]),
    .end_y      (req_data[4*C-1:3*C]),
    .colour_in  (req_data[4*C+31:4*C]),
    .pix_x      (pix_x),
    .pix_y      (pix_y),
    .pix_colour (pix_colour),
    .res        (res)
  );

  assign pix_data = OUT_W'({pix_colour, pix_y, pix_x});

  mlr_out_reg #(.DATA_W(OUT_W)) u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .res        (res),
    .data       (pix_data),
    .advance    (advance),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

### rtl/mlr_checker.sv
// Port-level checks for the midpoint line rasterizer, bound to the top level.
// Depends on mlr_pkg for command codes.
module mlr_checker #(
  parameter int COORD_BITS = 12
) (
  input logic clk,
  input logic rst_n,
  input logic in_tvalid,
  input logic in_tready,
  input logic in_tuser,
  input logic [((4*COORD_BITS+32+7)/8)*8-1:0] in_tdata,
  input logic out_tvalid,
  input logic out_tready,
  input logic [((2*COORD_BITS+32+7)/8)*8-1:0] out_tdata,
  input logic out_tlast
);

  localparam int C = COORD_BITS;

  logic in_acc, start_req, point_req;

  assign in_acc    = in_tvalid && in_tready;
  assign start_req = in_acc && (in_tuser == mlr_pkg::CMD_START);
  assign point_req = start_req && (in_tdata[C-1:0] == in_tdata[3*C-1:2*C])
                     && (in_tdata[2*C-1:C] == in_tdata[4*C-1:3*C]);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled pixel changed or dropped");

  a_start_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    start_req ##1 out_tready |=> out_tvalid
      && out_tdata[2*C+31:2*C] == $past(in_tdata[4*C+31:4*C], 2)
      && out_tdata[C-1:0] == $past(in_tdata[C-1:0], 2))
    else $error("start request did not yield its first pixel");

  a_point_last: assert property (@(posedge clk) disable iff (!rst_n)
    point_req ##1 out_tready |=> out_tvalid && out_tlast)
    else $error("single point line not marked last");

endmodule

bind midpoint_line_rasterizer mlr_checker #(.COORD_BITS(COORD_BITS)) u_mlr_checker (.*);

### bench/tb_top.sv
// Self-checking bench for midpoint_line_rasterizer: directed lines, then random line requests.
// Depends on mlr_pkg and the rasterizer RTL; a scoreboard class predicts every pixel.
`timescale 1ns / 1ps

module tb_top;

  localparam int LIMIT       = 400000;
  localparam int ITEM_TARGET = 1550;

  typedef struct {
    logic [11:0] x;
    logic [11:0] y;
    logic [31:0] colour;
    logic        last;
  } pixel_t;

  // Tracks the line being drawn and queues the pixels each request should produce.
  class pixel_scoreboard;
    pixel_t             due[$];
    int                 errors;
    logic [11:0]        cur_x, cur_y, tgt_x, tgt_y;
    logic signed [14:0] decision;
    logic [12:0]        major_d, minor_d;
    logic               neg_x, neg_y, y_major, active;
    logic [31:0]        colour;

    function new();
      errors   = 0;
      cur_x    = '0;
      cur_y    = '0;
      tgt_x    = '0;
      tgt_y    = '0;
      decision = '0;
      major_d  = '0;
      minor_d  = '0;
      neg_x    = 1'b0;
      neg_y    = 1'b0;
      y_major  = 1'b0;
      active   = 1'b0;
      colour   = '0;
    endfunction

    // Returns 1 when the request produces a pixel.
    function bit note_request(logic cmd, logic [79:0] word);
      int     dx, dy, ax, ay;
      pixel_t p;
      if (cmd == mlr_pkg::CMD_START) begin
        cur_x  = word[11:0];
        cur_y  = word[23:12];
        tgt_x  = word[35:24];
        tgt_y  = word[47:36];
        colour = word[79:48];
        dx     = int'(tgt_x) - int'(cur_x);
        dy     = int'(tgt_y) - int'(cur_y);
        neg_x  = dx < 0;
        neg_y  = dy < 0;
        ax     = neg_x ? -dx : dx;
        ay     = neg_y ? -dy : dy;
        // ties go to x as the major axis
        y_major  = ay > ax;
        major_d  = 13'(y_major ? ay : ax);
        minor_d  = 13'(y_major ? ax : ay);
        decision = 15'(2 * int'(minor_d) - int'(major_d));
        active   = major_d != 0;
      end else begin
        if (!active) return 0;
        if (y_major) begin
          cur_y = 12'(neg_y ? cur_y - 1 : cur_y + 1);
          if (decision > 0) begin
            cur_x    = 12'(neg_x ? cur_x - 1 : cur_x + 1);
            decision = 15'(int'(decision) + 2 * int'(minor_d) - 2 * int'(major_d));
          end else begin
            decision = 15'(int'(decision) + 2 * int'(minor_d));
          end
          active = cur_y != tgt_y;
        end else begin
          cur_x = 12'(neg_x ? cur_x - 1 : cur_x + 1);
          if (decision > 0) begin
            cur_y    = 12'(neg_y ? cur_y - 1 : cur_y + 1);
            decision = 15'(int'(decision) + 2 * int'(minor_d) - 2 * int'(major_d));
          end else begin
            decision = 15'(int'(decision) + 2 * int'(minor_d));
          end
          active = cur_x != tgt_x;
        end
      end
      p = '{x: cur_x, y: cur_y, colour: colour, last: !active};
      due.push_back(p);
      return 1;
    endfunction

    function void check_pixel(logic [55:0] word, logic lst);
      pixel_t p;
      if (due.size() == 0) begin
        $error("unexpected pixel x=%0d y=%0d colour=%h last=%b",
               word[11:0], word[23:12], word[55:24], lst);
        errors++;
        return;
      end
      p = due.pop_front();
      if (word[11:0] !== p.x) begin
        $error("pixel_x: expected %0d, got %0d", p.x, word[11:0]);
        errors++;
      end
      if (word[23:12] !== p.y) begin
        $error("pixel_y: expected %0d, got %0d", p.y, word[23:12]);
        errors++;
      end
      if (word[55:24] !== p.colour) begin
        $error("pixel_colour: expected %h, got %h", p.colour, word[55:24]);
        errors++;
      end
      if (lst !== p.last) begin
        $error("last: expected %b, got %b", p.last, lst);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic        in_tuser;   // command
  logic [79:0] in_tdata;   // start_x, start_y, end_x, end_y, colour_in
  logic        out_tvalid;
  logic        out_tready;
  logic [55:0] out_tdata;  // pixel_x, pixel_y, pixel_colour
  logic        out_tlast;  // last

  pixel_scoreboard sb = new();
  int  results_due;
  int  requests_sent;
  int  pixels_seen;
  int  cycles;
  bit  calm;

  midpoint_line_rasterizer i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("status: fail");
    $finish;
  end

  // Result side: random back-pressure plus one long hold so the pipe fills up.
  initial begin
    int hold_left;
    bit held_once;
    hold_left   = 0;
    held_once   = 1'b0;
    pixels_seen = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        sb.check_pixel(out_tdata, out_tlast);
        pixels_seen++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (!held_once && pixels_seen == 300) begin
        held_once = 1'b1;
        hold_left = 400;
        out_tready <= 1'b0;
      end else begin
        out_tready <= calm || ($urandom_range(99) >= 16);
      end
    end
  end

  function automatic logic [79:0] line_word(logic [11:0] sx, logic [11:0] sy,
                                            logic [11:0] ex, logic [11:0] ey,
                                            logic [31:0] col);
    return {col, ey, ex, sy, sx};
  endfunction

  // Valid drops for random gaps before a request unless calm is set, and also when idling or draining.
  task automatic send_request(input logic cmd, input logic [79:0] word);
    if (!calm) begin
      while ($urandom_range(99) < 16) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= word;
    do @(posedge clk); while (!in_tready);
    requests_sent++;
    if (sb.note_request(cmd, word)) results_due++;
  endtask

  task automatic run_line(input logic [11:0] sx, input logic [11:0] sy,
                          input logic [11:0] ex, input logic [11:0] ey,
                          input logic [31:0] col, input int steps);
    send_request(mlr_pkg::CMD_START, line_word(sx, sy, ex, ey, col));
    // step requests carry junk in tdata; the block must ignore it
    repeat (steps) send_request(mlr_pkg::CMD_STEP, 80'({$urandom(), $urandom(), $urandom()}));
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.due.size() != 0) @(posedge clk);
  endtask

  initial begin
    int          kind, major, steps;
    bit          paused_once;
    logic [11:0] sx, sy, ex, ey;
    paused_once   = 1'b0;
    results_due   = 0;
    requests_sent = 0;
    calm          = 1'b0;
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tuser   <= mlr_pkg::CMD_START;
    in_tdata   <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: step with no line, single point, extremes, abandon, ties, axes
    send_request(mlr_pkg::CMD_STEP, '1);
    run_line(12'd0, 12'd0, 12'd0, 12'd0, 32'h0000_0000, 1);
    run_line(12'd0, 12'd0, 12'd4095, 12'd4095, 32'hFFFF_FFFF, 2);
    run_line(12'd4095, 12'd0, 12'd0, 12'd4095, 32'h8000_0001, 1);
    run_line(12'd10, 12'd10, 12'd13, 12'd7, 32'h1234_5678, 4);      // equal extents
    run_line(12'd100, 12'd100, 12'd98, 12'd105, 32'hA5A5_5A5A, 5);  // y major, x down
    run_line(12'd4095, 12'd4095, 12'd4093, 12'd4094, 32'h0F0F_F0F0, 2);
    run_line(12'd0, 12'd4095, 12'd2, 12'd4094, 32'hDEAD_BEEF, 2);   // midpoint tie
    drain();

    while (requests_sent < ITEM_TARGET) begin
      calm = (results_due >= 1000) && (results_due < 1250);
      if (!paused_once && results_due >= 700) begin
        drain();
        paused_once = 1'b1;
      end
      kind = $urandom_range(99);
      sx   = 12'($urandom_range(4095));
      sy   = 12'($urandom_range(4095));
      if (kind < 70) begin
        ex    = 12'($urandom_range(sx < 4075 ? sx + 20 : 4095, sx > 20 ? sx - 20 : 0));
        ey    = 12'($urandom_range(sy < 4075 ? sy + 20 : 4095, sy > 20 ? sy - 20 : 0));
        major = (ex > sx ? ex - sx : sx - ex);
        if ((ey > sy ? ey - sy : sy - ey) > major) major = (ey > sy ? ey - sy : sy - ey);
        // mostly complete lines with a few trailing steps; some get abandoned early
        steps = ($urandom_range(4) == 0) ? $urandom_range(major) : major + $urandom_range(2);
        run_line(sx, sy, ex, ey, $urandom(), steps);
      end else if (kind < 80) begin
        run_line(sx, sy, 12'($urandom_range(4095)), 12'($urandom_range(4095)),
                 $urandom(), $urandom_range(40));
      end else if (kind < 85) begin
        run_line($urandom_range(1) ? 12'd4095 : 12'd0, $urandom_range(1) ? 12'd4095 : 12'd0,
                 $urandom_range(1) ? 12'd4095 : 12'd0, $urandom_range(1) ? 12'd4095 : 12'd0,
                 $urandom(), $urandom_range(10));
      end else begin
        send_request(logic'($urandom_range(1)), 80'({$urandom(), $urandom(), $urandom()}));
      end
    end

    calm = 1'b0;
    drain();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/mlr_pkg.sv
rtl/mlr_in_reg.sv
rtl/mlr_core.sv
rtl/mlr_out_reg.sv
rtl/midpoint_line_rasterizer.sv
rtl/mlr_checker.sv
bench/tb_top.sv
